// File: src/lnk_pkg.sv
// ----------------------------------------------------------------------------
// Linkage descriptor parser package
// Parse phases, field codes and the state and result records that the
// decoder and the top level share.
// ----------------------------------------------------------------------------
package lnk_pkg;

	// Parse phases.
	localparam logic [4:0] PH_FIXED    = 5'd0;
	localparam logic [4:0] PH_HO_FLAGS = 5'd1;
	localparam logic [4:0] PH_HO_NET_H = 5'd2;
	localparam logic [4:0] PH_HO_NET_L = 5'd3;
	localparam logic [4:0] PH_HO_SVC_H = 5'd4;
	localparam logic [4:0] PH_HO_SVC_L = 5'd5;
	localparam logic [4:0] PH_EV_ID_H  = 5'd6;
	localparam logic [4:0] PH_EV_ID_L  = 5'd7;
	localparam logic [4:0] PH_EV_FLAGS = 5'd8;
	localparam logic [4:0] PH_EXT_LEN  = 5'd9;
	localparam logic [4:0] PH_X_ID_H   = 5'd10;
	localparam logic [4:0] PH_X_ID_L   = 5'd11;
	localparam logic [4:0] PH_X_FLAGS  = 5'd12;
	localparam logic [4:0] PH_X_USR_H  = 5'd13;
	localparam logic [4:0] PH_X_USR_L  = 5'd14;
	localparam logic [4:0] PH_X_TS_H   = 5'd15;
	localparam logic [4:0] PH_X_TS_L   = 5'd16;
	localparam logic [4:0] PH_X_ON_H   = 5'd17;
	localparam logic [4:0] PH_X_ON_L   = 5'd18;
	localparam logic [4:0] PH_X_SV_H   = 5'd19;
	localparam logic [4:0] PH_X_SV_L   = 5'd20;
	localparam logic [4:0] PH_PRIVATE  = 5'd21;

	// Result field codes.
	localparam logic [4:0] FC_TSID     = 5'd0;
	localparam logic [4:0] FC_LTYPE    = 5'd3;
	localparam logic [4:0] FC_HANDOVER = 5'd4;
	localparam logic [4:0] FC_NETID    = 5'd5;
	localparam logic [4:0] FC_INITSVC  = 5'd6;
	localparam logic [4:0] FC_EVID     = 5'd7;
	localparam logic [4:0] FC_EVFLAGS  = 5'd8;
	localparam logic [4:0] FC_XEVID    = 5'd9;
	localparam logic [4:0] FC_XFLAGS   = 5'd10;
	localparam logic [4:0] FC_USERID   = 5'd11;
	localparam logic [4:0] FC_XTSID    = 5'd12;
	localparam logic [4:0] FC_XONID    = 5'd13;
	localparam logic [4:0] FC_XSVC     = 5'd14;
	localparam logic [4:0] FC_PRIVATE  = 5'd15;
	localparam logic [4:0] FC_OK       = 5'd16;
	localparam logic [4:0] FC_ERROR    = 5'd17;

	// Id kinds of an extended event entry that carry an extra id.
	localparam logic [1:0] IDK_TSID = 2'd1;
	localparam logic [1:0] IDK_USER = 2'd3;

	// Minimum loop bytes for a new entry and for an optional id.
	localparam logic [7:0] ENTRY_MIN_BYTES = 8'd3;
	localparam logic [7:0] ID_BYTES        = 8'd2;

	// Byte position of the linkage type in the fixed part.
	localparam logic [2:0] LTYPE_POS = 3'd6;

	typedef struct packed {
		logic [4:0] phase;
		logic [2:0] fixed_pos;
		logic [7:0] held;
		logic [7:0] layout;
		logic [7:0] loop_left;
		logic [3:0] ho_kind;
		logic       origin;
		logic [1:0] id_kind;
		logic       onid_present;
		logic       svc_present;
		logic [6:0] entry_count;
		logic       error_seen;
	} parse_state_t;

	typedef struct packed {
		logic [4:0]  code;
		logic [15:0] value;
		logic [6:0]  index;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0] handover_code;
		logic [7:0] event_code;
		logic [7:0] ext_min_code;
		logic [7:0] ext_max_code;
	} lnk_cfg_t;

endpackage

// File: src/lnk_decoder.sv
// ----------------------------------------------------------------------------
// Linkage descriptor byte decoder
// Combinational next-state and result logic for one payload byte: up to
// one decoded field followed by an optional end-of-descriptor status.
// ----------------------------------------------------------------------------
module lnk_decoder import lnk_pkg::*; (
	input  parse_state_t st,
	input  lnk_cfg_t     cfg,
	input  logic [7:0]   payload_byte,
	input  logic         end_of_payload,
	output parse_state_t nxt,
	output result_t      res0,
	output result_t      res1,
	output logic [1:0]   res_count
);

	always_comb begin
		parse_state_t n;
		logic         fld_valid;
		result_t      fld;
		result_t      stat;
		logic         ea_go;
		logic [2:0]   ea_done;
		logic         eb_go;
		logic         nx_found;
		logic [4:0]   nx_phase;
		logic [15:0]  w;
		logic         ok;

		n         = st;
		fld_valid = 1'b0;
		fld       = '0;
		stat      = '0;
		ea_go     = 1'b0;
		ea_done   = 3'd0;
		eb_go     = 1'b0;
		nx_found  = 1'b0;
		nx_phase  = PH_FIXED;
		w         = {st.held, payload_byte};
		ok        = 1'b0;

		// Decode the byte unless an error already stopped the descriptor.
		if (!st.error_seen) begin
			case (st.phase)
				PH_FIXED: begin
					if (st.fixed_pos == LTYPE_POS) begin
						n.layout  = payload_byte;
						fld_valid = 1'b1;
						fld.code  = FC_LTYPE;
						fld.value = {8'd0, payload_byte};
						// First matching layout wins.
						if (payload_byte == cfg.handover_code) begin
							n.phase = PH_HO_FLAGS;
						end else if (payload_byte == cfg.event_code) begin
							n.phase = PH_EV_ID_H;
						end else if (payload_byte >= cfg.ext_min_code &&
						             payload_byte <= cfg.ext_max_code) begin
							n.phase = PH_EXT_LEN;
						end else begin
							n.phase = PH_PRIVATE;
						end
					end else begin
						if (st.fixed_pos[0]) begin
							fld_valid = 1'b1;
							fld.code  = FC_TSID + {3'd0, st.fixed_pos[2:1]};
							fld.value = w;
						end else begin
							n.held = payload_byte;
						end
						n.fixed_pos = st.fixed_pos + 3'd1;
					end
				end
				PH_HO_FLAGS: begin
					n.ho_kind = payload_byte[7:4];
					n.origin  = payload_byte[0];
					fld_valid = 1'b1;
					fld.code  = FC_HANDOVER;
					fld.value = {11'd0, payload_byte[7:4], payload_byte[0]};
					if (payload_byte[7:4] >= 4'd1 && payload_byte[7:4] <= 4'd3) begin
						n.phase = PH_HO_NET_H;
					end else begin
						n.phase = payload_byte[0] ? PH_PRIVATE : PH_HO_SVC_H;
					end
				end
				PH_HO_NET_L: begin
					fld_valid = 1'b1;
					fld.code  = FC_NETID;
					fld.value = w;
					n.phase   = st.origin ? PH_PRIVATE : PH_HO_SVC_H;
				end
				PH_HO_SVC_L: begin
					fld_valid = 1'b1;
					fld.code  = FC_INITSVC;
					fld.value = w;
					n.phase   = PH_PRIVATE;
				end
				PH_EV_ID_L: begin
					fld_valid = 1'b1;
					fld.code  = FC_EVID;
					fld.value = w;
					n.phase   = PH_EV_FLAGS;
				end
				PH_EV_FLAGS: begin
					fld_valid = 1'b1;
					fld.code  = FC_EVFLAGS;
					fld.value = {14'd0, payload_byte[7], payload_byte[6]};
					n.phase   = PH_PRIVATE;
				end
				PH_EXT_LEN: begin
					n.loop_left = payload_byte;
					eb_go       = 1'b1;
				end
				PH_X_ID_L: begin
					fld_valid = 1'b1;
					fld.code  = FC_XEVID;
					fld.value = w;
					fld.index = st.entry_count;
					n.phase   = PH_X_FLAGS;
				end
				PH_X_FLAGS: begin
					fld_valid      = 1'b1;
					fld.code       = FC_XFLAGS;
					fld.value      = {10'd0, payload_byte[7:2]};
					fld.index      = st.entry_count;
					n.id_kind      = payload_byte[3:2];
					n.onid_present = payload_byte[1];
					n.svc_present  = payload_byte[0];
					n.loop_left    = st.loop_left - ENTRY_MIN_BYTES;
					ea_go          = 1'b1;
					ea_done        = 3'd0;
				end
				PH_X_USR_L, PH_X_TS_L, PH_X_ON_L, PH_X_SV_L: begin
					fld_valid   = 1'b1;
					fld.value   = w;
					fld.index   = st.entry_count;
					n.loop_left = st.loop_left - ID_BYTES;
					ea_go       = 1'b1;
					case (st.phase)
						PH_X_USR_L: begin
							fld.code = FC_USERID;
							ea_done  = 3'd1;
						end
						PH_X_TS_L: begin
							fld.code = FC_XTSID;
							ea_done  = 3'd2;
						end
						PH_X_ON_L: begin
							fld.code = FC_XONID;
							ea_done  = 3'd3;
						end
						default: begin
							fld.code = FC_XSVC;
							ea_done  = 3'd4;
						end
					endcase
				end
				PH_PRIVATE: begin
					fld_valid = 1'b1;
					fld.code  = FC_PRIVATE;
					fld.value = {8'd0, payload_byte};
				end
				PH_HO_NET_H, PH_HO_SVC_H, PH_EV_ID_H, PH_X_ID_H,
				PH_X_USR_H, PH_X_TS_H, PH_X_ON_H, PH_X_SV_H: begin
					n.held  = payload_byte;
					n.phase = st.phase + 5'd1;
				end
				default: begin
					n.error_seen = 1'b1;
				end
			endcase
		end

		// Move to the next optional id of the entry, or close the entry.
		if (ea_go) begin
			if (ea_done < 3'd1 && n.id_kind == IDK_USER) begin
				nx_found = 1'b1;
				nx_phase = PH_X_USR_H;
			end else if (ea_done < 3'd2 && n.id_kind == IDK_TSID) begin
				nx_found = 1'b1;
				nx_phase = PH_X_TS_H;
			end else if (ea_done < 3'd3 && n.onid_present) begin
				nx_found = 1'b1;
				nx_phase = PH_X_ON_H;
			end else if (ea_done < 3'd4 && n.svc_present) begin
				nx_found = 1'b1;
				nx_phase = PH_X_SV_H;
			end
			if (!nx_found) begin
				n.entry_count = n.entry_count + 7'd1;
				eb_go         = 1'b1;
			end else if (n.loop_left < ID_BYTES) begin
				n.error_seen = 1'b1;
			end else begin
				n.phase = nx_phase;
			end
		end

		// Entry boundary: leave the loop, start an entry, or flag an overrun.
		if (eb_go) begin
			if (n.loop_left == 8'd0) begin
				n.phase = PH_PRIVATE;
			end else if (n.loop_left < ENTRY_MIN_BYTES) begin
				n.error_seen = 1'b1;
			end else begin
				n.phase = PH_X_ID_H;
			end
		end

		// End mark: status result and a clean state for the next descriptor.
		ok        = !n.error_seen && n.phase == PH_PRIVATE;
		stat.code = ok ? FC_OK : FC_ERROR;
		stat.last = 1'b1;
		if (end_of_payload) begin
			n = '0;
		end
		fld.last = !end_of_payload;

		nxt = n;
		if (fld_valid) begin
			res0      = fld;
			res1      = stat;
			res_count = end_of_payload ? 2'd2 : 2'd1;
		end else begin
			res0      = stat;
			res1      = stat;
			res_count = end_of_payload ? 2'd1 : 2'd0;
		end
	end

endmodule

// File: src/linkage_descriptor_parser_unit.sv
// ----------------------------------------------------------------------------
// Linkage descriptor parser unit
// Decodes DVB linkage descriptor payload bytes into (code, value) results.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle. Each byte passes an input
// register and is decoded from it into at most one field result,
// plus an ok or error status on the byte that carries the end mark; results
// go into a three-entry output queue. The input register advances whenever
// the queue holds at most one result, so with out_ready high the sustained
// rate is one byte per clock; the byte with the end mark may hold the input
// while its second result drains through the single output port. After reset
// the block is ready at once. Configuration registers sit on an APB port at
// byte offsets 0, 4, 8 and 12 and are meant to be written between
// descriptors.
module linkage_descriptor_parser_unit import lnk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Byte transactions.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        end_of_payload,
	// Result transactions.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  field_code,
	output logic [15:0] field_value,
	output logic [6:0]  entry_index,
	output logic        last_of_run,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] REG_HANDOVER = 2'd0;
	localparam logic [1:0] REG_EVENT    = 2'd1;
	localparam logic [1:0] REG_EXT_MIN  = 2'd2;
	localparam logic [1:0] REG_EXT_MAX  = 2'd3;
	localparam int         QDEPTH       = 3;

	lnk_cfg_t     cfg_q;
	parse_state_t st_q;
	parse_state_t st_nxt;
	result_t      res0;
	result_t      res1;
	logic [1:0]   res_count;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         end_s1;
	logic         advance;
	logic         pop;
	result_t      queue_q [QDEPTH];
	result_t      queue_n [QDEPTH];
	logic [1:0]   cnt_q;
	logic [1:0]   cnt_n;
	logic [1:0]   base;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.handover_code <= 8'd8;
			cfg_q.event_code    <= 8'd13;
			cfg_q.ext_min_code  <= 8'd14;
			cfg_q.ext_max_code  <= 8'd31;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_HANDOVER: cfg_q.handover_code <= pwdata[7:0];
				REG_EVENT:    cfg_q.event_code    <= pwdata[7:0];
				REG_EXT_MIN:  cfg_q.ext_min_code  <= pwdata[7:0];
				REG_EXT_MAX:  cfg_q.ext_max_code  <= pwdata[7:0];
				default:      cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HANDOVER: prdata = {24'd0, cfg_q.handover_code};
			REG_EVENT:    prdata = {24'd0, cfg_q.event_code};
			REG_EXT_MIN:  prdata = {24'd0, cfg_q.ext_min_code};
			REG_EXT_MAX:  prdata = {24'd0, cfg_q.ext_max_code};
			default:      prdata = 32'd0;
		endcase
	end

	// Input register; it advances while the queue has room for two results.
	assign advance  = valid_s1 && (cnt_q <= 2'd1);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= payload_byte;
			end_s1  <= end_of_payload;
		end
	end

	// Byte decode.
	lnk_decoder u_decoder (
		.st             (st_q),
		.cfg            (cfg_q),
		.payload_byte   (byte_s1),
		.end_of_payload (end_s1),
		.nxt            (st_nxt),
		.res0           (res0),
		.res1           (res1),
		.res_count      (res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Output queue: the head is slot zero, pops shift the rest down.
	assign out_valid   = cnt_q != 2'd0;
	assign pop         = out_valid && out_ready;
	assign field_code  = queue_q[0].code;
	assign field_value = queue_q[0].value;
	assign entry_index = queue_q[0].index;
	assign last_of_run = queue_q[0].last;

	always_comb begin
		base    = cnt_q - {1'b0, pop};
		cnt_n   = base + (advance ? res_count : 2'd0);
		queue_n = queue_q;
		if (pop) begin
			for (int i = 0; i < QDEPTH - 1; i++) begin
				queue_n[i] = queue_q[i + 1];
			end
		end
		for (int i = 0; i < QDEPTH; i++) begin
			if (advance && res_count != 2'd0 && i[1:0] == base) begin
				queue_n[i] = res0;
			end else if (advance && res_count == 2'd2 && i[1:0] == base + 2'd1) begin
				queue_n[i] = res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		queue_q <= queue_n;
	end

	// A status result always closes the run of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (field_code == FC_OK || field_code == FC_ERROR) |-> last_of_run)
		else $error("status result without last_of_run");

	// Only extended loop fields carry an entry number.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (field_code < FC_XEVID || field_code > FC_XSVC) |-> entry_index == 7'd0)
		else $error("entry_index set on a non-loop field");

	// The end mark leaves the parser clean for the next descriptor.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> st_q.phase == PH_FIXED && st_q.fixed_pos == 3'd0 &&
			!st_q.error_seen && st_q.entry_count == 7'd0)
		else $error("parser state not cleared after end of payload");

endmodule

// File: test/tb_lnk_regs_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linkage parser test register map
// Byte addresses and reset values of the layout-code registers, shared by
// the stimulus top and the checker.
// ----------------------------------------------------------------------------
package tb_lnk_regs_pkg;

	// Register byte addresses on the configuration port.
	localparam logic [3:0] ADDR_HANDOVER_CODE = 4'h0;
	localparam logic [3:0] ADDR_EVENT_CODE    = 4'h4;
	localparam logic [3:0] ADDR_EXT_MIN_CODE  = 4'h8;
	localparam logic [3:0] ADDR_EXT_MAX_CODE  = 4'hC;

	// Register values after reset.
	localparam logic [7:0] DEF_HANDOVER_CODE = 8'd8;
	localparam logic [7:0] DEF_EVENT_CODE    = 8'd13;
	localparam logic [7:0] DEF_EXT_MIN_CODE  = 8'd14;
	localparam logic [7:0] DEF_EXT_MAX_CODE  = 8'd31;

endpackage

// File: test/linkage_descriptor_parser_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linkage descriptor parser checker
// Watches the byte, result and configuration ports, decodes every accepted
// byte up to an error with its own descriptor parser and compares each
// result transaction field by field with the oldest expected field.
// ----------------------------------------------------------------------------
module linkage_descriptor_parser_checker import lnk_pkg::*, tb_lnk_regs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        end_of_payload,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  field_code,
	input  logic [15:0] field_value,
	input  logic [6:0]  entry_index,
	input  logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          outstanding,
	output int          decoded_bytes,
	output int          results_checked
);

	// Layout codes as last written.
	lnk_cfg_t layout_codes;

	// Decoded fields still waiting for their result transaction.
	result_t expected_fields[$];

	// Parser state.
	logic [4:0] ph;
	logic [2:0] fpos;
	logic [7:0] hi_byte;
	logic [7:0] ltype;
	logic [7:0] loop_left;
	logic [3:0] ho_kind;
	logic       orig;
	logic [1:0] idk;
	logic       onid_f;
	logic       svc_f;
	logic [6:0] n_entry;
	logic       err;

	int errs      = 0;
	int n_bytes   = 0;
	int n_checked = 0;

	task automatic clear_parse();
		ph        = PH_FIXED;
		fpos      = '0;
		hi_byte   = '0;
		ltype     = '0;
		loop_left = '0;
		ho_kind   = '0;
		orig      = 1'b0;
		idk       = '0;
		onid_f    = 1'b0;
		svc_f     = 1'b0;
		n_entry   = '0;
		err       = 1'b0;
	endtask

	task automatic push_field(input logic [4:0] code, input logic [15:0] value,
			input logic [6:0] idx);
		result_t r;
		r.code  = code;
		r.value = value;
		r.index = idx;
		r.last  = 1'b0;
		expected_fields = {expected_fields, r};
	endtask

	// Start the next loop entry, leave the loop, or flag an overrun.
	task automatic next_entry();
		if (loop_left == 0) begin
			ph = PH_PRIVATE;
		end else if (loop_left < ENTRY_MIN_BYTES) begin
			err = 1'b1;
		end else begin
			ph = PH_X_ID_H;
		end
	endtask

	// Move to the next optional id of the entry, given the phase just finished.
	task automatic next_field(input logic [4:0] done);
		logic [4:0] nxt;
		nxt = PH_FIXED;
		if (done < PH_X_USR_L && idk == IDK_USER) begin
			nxt = PH_X_USR_H;
		end else if (done < PH_X_TS_L && idk == IDK_TSID) begin
			nxt = PH_X_TS_H;
		end else if (done < PH_X_ON_L && onid_f) begin
			nxt = PH_X_ON_H;
		end else if (done < PH_X_SV_L && svc_f) begin
			nxt = PH_X_SV_H;
		end
		if (nxt == PH_FIXED) begin
			n_entry = n_entry + 7'd1;
			next_entry();
		end else if (loop_left < ID_BYTES) begin
			err = 1'b1;
		end else begin
			ph = nxt;
		end
	endtask

	// The first matching layout wins: hand-over, then event, then extended.
	task automatic choose_layout();
		if (ltype == layout_codes.handover_code) begin
			ph = PH_HO_FLAGS;
		end else if (ltype == layout_codes.event_code) begin
			ph = PH_EV_ID_H;
		end else if (ltype >= layout_codes.ext_min_code && ltype <= layout_codes.ext_max_code) begin
			ph = PH_EXT_LEN;
		end else begin
			ph = PH_PRIVATE;
		end
	endtask

	task automatic after_network_id();
		ph = orig ? PH_PRIVATE : PH_HO_SVC_H;
	endtask

	task automatic decode_payload_byte(input logic [7:0] b);
		logic [15:0] w;
		logic [6:0]  ei;
		w  = {hi_byte, b};
		ei = n_entry;
		case (ph)
			PH_FIXED: begin
				if (fpos == LTYPE_POS) begin
					ltype = b;
					push_field(FC_LTYPE, {8'h00, b}, 7'd0);
					choose_layout();
				end else begin
					if (fpos[0])
						push_field(FC_TSID + 5'(fpos >> 1), w, 7'd0);
					else
						hi_byte = b;
					fpos = fpos + 3'd1;
				end
			end
			PH_HO_FLAGS: begin
				ho_kind = b[7:4];
				orig    = b[0];
				push_field(FC_HANDOVER, {11'd0, ho_kind, orig}, 7'd0);
				// Hand-over kinds one to three carry a network id.
				if (ho_kind >= 4'd1 && ho_kind <= 4'd3)
					ph = PH_HO_NET_H;
				else
					after_network_id();
			end
			PH_HO_NET_L: begin
				push_field(FC_NETID, w, 7'd0);
				after_network_id();
			end
			PH_HO_SVC_L: begin
				push_field(FC_INITSVC, w, 7'd0);
				ph = PH_PRIVATE;
			end
			PH_EV_ID_L: begin
				push_field(FC_EVID, w, 7'd0);
				ph = PH_EV_FLAGS;
			end
			PH_EV_FLAGS: begin
				push_field(FC_EVFLAGS, {14'd0, b[7], b[6]}, 7'd0);
				ph = PH_PRIVATE;
			end
			PH_EXT_LEN: begin
				loop_left = b;
				next_entry();
			end
			PH_X_ID_L: begin
				push_field(FC_XEVID, w, ei);
				ph = PH_X_FLAGS;
			end
			PH_X_FLAGS: begin
				push_field(FC_XFLAGS, {10'd0, b[7:2]}, ei);
				idk       = b[3:2];
				onid_f    = b[1];
				svc_f     = b[0];
				loop_left = loop_left - ENTRY_MIN_BYTES;
				next_field(PH_X_FLAGS);
			end
			PH_X_USR_L, PH_X_TS_L, PH_X_ON_L, PH_X_SV_L: begin
				push_field(FC_USERID + 5'((ph - PH_X_USR_L) >> 1), w, ei);
				loop_left = loop_left - ID_BYTES;
				next_field(ph);
			end
			PH_PRIVATE: begin
				push_field(FC_PRIVATE, {8'h00, b}, 7'd0);
			end
			PH_HO_NET_H, PH_HO_SVC_H, PH_EV_ID_H, PH_X_ID_H,
			PH_X_USR_H, PH_X_TS_H, PH_X_ON_H, PH_X_SV_H: begin
				hi_byte = b;
				ph      = ph + 5'd1;
			end
			default: begin
				err = 1'b1;
			end
		endcase
	endtask

	// One accepted byte: decode it unless in error, then close the descriptor
	// on the end mark. The final field of the byte carries the last flag.
	task automatic take_byte(input logic [7:0] b, input logic eop);
		int      start_size;
		result_t r;
		start_size = expected_fields.size();
		if (!err) begin
			n_bytes++;
			decode_payload_byte(b);
		end
		if (eop) begin
			push_field((!err && ph == PH_PRIVATE) ? FC_OK : FC_ERROR, 16'd0, 7'd0);
			clear_parse();
		end
		if (expected_fields.size() > start_size) begin
			r      = expected_fields.pop_back();
			r.last = 1'b1;
			expected_fields = {expected_fields, r};
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errs++;
		end
	endtask

	// Register writes, result transactions, then byte transactions.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			layout_codes.handover_code = DEF_HANDOVER_CODE;
			layout_codes.event_code    = DEF_EVENT_CODE;
			layout_codes.ext_min_code  = DEF_EXT_MIN_CODE;
			layout_codes.ext_max_code  = DEF_EXT_MAX_CODE;
			clear_parse();
			expected_fields.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_HANDOVER_CODE: layout_codes.handover_code = pwdata[7:0];
					ADDR_EVENT_CODE:    layout_codes.event_code    = pwdata[7:0];
					ADDR_EXT_MIN_CODE:  layout_codes.ext_min_code  = pwdata[7:0];
					ADDR_EXT_MAX_CODE:  layout_codes.ext_max_code  = pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_fields.size() == 0) begin
					$error("unexpected result: code %0d value %0d index %0d",
						field_code, field_value, entry_index);
					errs++;
				end else begin
					want = expected_fields.pop_front();
					check_field("field_code", want.code, field_code);
					check_field("field_value", want.value, field_value);
					check_field("entry_index", want.index, entry_index);
					check_field("last_of_run", want.last, last_of_run);
					n_checked++;
				end
			end
			if (in_valid && in_ready)
				take_byte(payload_byte, end_of_payload);
		end
		fail_count      <= errs;
		outstanding     <= expected_fields.size();
		decoded_bytes   <= n_bytes;
		results_checked <= n_checked;
	end

endmodule

// File: test/tb_linkage_descriptor_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linkage descriptor parser unit testbench
// Drives whole descriptors (directed ones, then random well-formed, broken
// and noise ones) under five sets of layout codes, with random idling on
// both channels, a long result stall and a stretch without gaps. A checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_linkage_descriptor_parser_unit;
	import tb_lnk_regs_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 70;

	typedef enum {LAY_HO, LAY_EV, LAY_EXT, LAY_NONE} layout_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  payload_byte   = 8'h00;
	logic        end_of_payload = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [4:0]  field_code;
	logic [15:0] field_value;
	logic [6:0]  entry_index;
	logic        last_of_run;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [3:0]  paddr          = 4'h0;
	logic [31:0] pwdata         = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int outstanding;
	int decoded_bytes;
	int results_checked;

	// Stimulus controls and the current layout codes.
	logic       quiet     = 1'b0;
	int         hold_asks = 0;
	int         hold_done = 0;
	int         hold_left = 0;
	int         cycles    = 0;
	int         n_desc    = 0;
	logic [7:0] cur_ho    = DEF_HANDOVER_CODE;
	logic [7:0] cur_ev    = DEF_EVENT_CODE;
	logic [7:0] cur_min   = DEF_EXT_MIN_CODE;
	logic [7:0] cur_max   = DEF_EXT_MAX_CODE;
	logic [7:0] desc_bytes[$];

	linkage_descriptor_parser_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.payload_byte   (payload_byte),
		.end_of_payload (end_of_payload),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_code     (field_code),
		.field_value    (field_value),
		.entry_index    (entry_index),
		.last_of_run    (last_of_run),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	linkage_descriptor_parser_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.payload_byte    (payload_byte),
		.end_of_payload  (end_of_payload),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.field_code      (field_code),
		.field_value     (field_value),
		.entry_index     (entry_index),
		.last_of_run     (last_of_run),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.decoded_bytes   (decoded_bytes),
		.results_checked (results_checked)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stalls, or a long hold-off when one is asked for.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 11);
		end
	end

	// Run limit.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offer one byte transaction, after random idle cycles, and wait for it.
	task automatic send_byte(input logic [7:0] b, input logic eop);
		while (!quiet && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		payload_byte   <= b;
		end_of_payload <= eop;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_desc();
		foreach (desc_bytes[i])
			send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
		n_desc++;
	endtask

	task automatic add_random(input int n);
		repeat (n)
			desc_bytes = {desc_bytes, 8'($urandom)};
	endtask

	function automatic layout_t layout_of(input logic [7:0] t);
		if (t == cur_ho)
			return LAY_HO;
		if (t == cur_ev)
			return LAY_EV;
		if (t >= cur_min && t <= cur_max)
			return LAY_EXT;
		return LAY_NONE;
	endfunction

	// Build one descriptor aiming at a layout. A broken one gets a wrong loop
	// length or loses its tail. A negative entry count means random; plain
	// entries carry no optional ids.
	task automatic build_desc(input layout_t want, input bit broken, input int entries,
			input bit plain);
		logic [7:0] t;
		logic [7:0] fl;
		layout_t    lay;
		int         n_ent;
		int         loop_len;
		int         tries;
		logic [7:0] loop_q[$];
		desc_bytes.delete();
		add_random(6);
		case (want)
			LAY_HO: t = cur_ho;
			LAY_EV: t = cur_ev;
			default: begin
				t = 8'($urandom);
				if (want == LAY_EXT && cur_min <= cur_max)
					t = 8'($urandom_range(cur_max, cur_min));
				tries = 0;
				while (layout_of(t) != want && tries < 32) begin
					t = 8'($urandom);
					tries++;
				end
			end
		endcase
		desc_bytes = {desc_bytes, t};
		lay = layout_of(t);
		case (lay)
			LAY_HO: begin
				fl = 8'($urandom);
				if ($urandom_range(1))
					fl[7:4] = 4'($urandom_range(3, 1));
				desc_bytes = {desc_bytes, fl};
				if (fl[7:4] >= 4'd1 && fl[7:4] <= 4'd3)
					add_random(2);
				if (!fl[0])
					add_random(2);
			end
			LAY_EV: begin
				add_random(3);
			end
			LAY_EXT: begin
				n_ent = (entries < 0) ? $urandom_range(3) : entries;
				repeat (n_ent) begin
					repeat (2)
						loop_q = {loop_q, 8'($urandom)};
					fl = 8'($urandom);
					if (plain)
						fl[3:0] = {fl[3], 3'b000};
					loop_q = {loop_q, fl};
					if (fl[3:2] == lnk_pkg::IDK_USER || fl[3:2] == lnk_pkg::IDK_TSID)
						repeat (2) loop_q = {loop_q, 8'($urandom)};
					if (fl[1])
						repeat (2) loop_q = {loop_q, 8'($urandom)};
					if (fl[0])
						repeat (2) loop_q = {loop_q, 8'($urandom)};
				end
				loop_len = loop_q.size();
				if (broken && $urandom_range(1)) begin
					loop_len = (loop_len > 0) ? $urandom_range(loop_len - 1, 0)
						: $urandom_range(255, 1);
					broken = 1'b0;
				end
				desc_bytes = {desc_bytes, 8'(loop_len)};
				foreach (loop_q[i])
					desc_bytes = {desc_bytes, loop_q[i]};
			end
			default: ;
		endcase
		add_random($urandom_range(3));
		if (broken)
			repeat ($urandom_range(desc_bytes.size() - 1, 1))
				desc_bytes.pop_back();
	endtask

	// Random descriptors until enough bytes have been decoded.
	task automatic run_random(input int count);
		int goal;
		int r;
		goal = decoded_bytes + count;
		while (decoded_bytes < goal) begin
			r = $urandom_range(99);
			if (r < 15) begin
				desc_bytes.delete();
				add_random($urandom_range(10, 1));
			end else begin
				build_desc(layout_t'($urandom_range(3)), r < 30, -1, 1'b0);
			end
			send_desc();
		end
	endtask

	// Wait until every expected result is out and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [3:0] addr, input logic [7:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'd0, data};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_codes(input logic [7:0] ho, input logic [7:0] ev,
			input logic [7:0] mn, input logic [7:0] mx);
		settle();
		apb_write(ADDR_HANDOVER_CODE, ho);
		apb_write(ADDR_EVENT_CODE, ev);
		apb_write(ADDR_EXT_MIN_CODE, mn);
		apb_write(ADDR_EXT_MAX_CODE, mx);
		cur_ho  = ho;
		cur_ev  = ev;
		cur_min = mn;
		cur_max = mx;
	endtask

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a one-byte payload, a complete hand-over with extreme
		// field values that ends on its last field, and an event linkage.
		desc_bytes = '{8'hFF};
		send_desc();
		desc_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, DEF_HANDOVER_CODE,
			8'h10, 8'hFF, 8'hFF, 8'h00, 8'h00};
		send_desc();
		desc_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, DEF_EVENT_CODE,
			8'h12, 8'h34, 8'hC0, 8'hAA};
		send_desc();

		run_random(PHASE_BYTES);

		// Extended layout over every other type; long result stall; one
		// descriptor with the longest possible loop.
		set_codes(8'd0, 8'd255, 8'd0, 8'd255);
		hold_asks <= hold_asks + 1;
		run_random(PHASE_BYTES);
		build_desc(LAY_EXT, 1'b0, 85, 1'b1);
		send_desc();

		// Empty extended range, no idling on either side.
		set_codes(8'd255, 8'd0, 8'd200, 8'd100);
		quiet <= 1'b1;
		run_random(PHASE_BYTES);
		quiet <= 1'b0;

		// All layouts on the same code: hand-over takes it.
		set_codes(8'd5, 8'd5, 8'd5, 8'd5);
		run_random(PHASE_BYTES);

		// Extended range overlapping both other codes.
		set_codes(8'd40, 8'd41, 8'd40, 8'd42);
		run_random(PHASE_BYTES);

		settle();
		$display("Sent %0d descriptors, %0d payload bytes decoded, under five layout-code sets.",
			n_desc, decoded_bytes);
		$display("Checked %0d results, with a full 85-entry loop and a %0d-cycle result stall.",
			results_checked, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
src/lnk_pkg.sv
src/lnk_decoder.sv
src/linkage_descriptor_parser_unit.sv
test/tb_lnk_regs_pkg.sv
test/linkage_descriptor_parser_checker.sv
test/tb_linkage_descriptor_parser_unit.sv
